/* src/csvt_pkg.sv */
// Shared types and constants of the delimited-text tokenizer.
// Holds result kinds, error codes, parse modes and character codes.
// No dependencies.
`default_nettype none

package csvt_pkg;

    localparam int POSITION_WIDTH_DEFAULT = 24;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [2:0] KIND_FIELD_BYTE = 3'd0;
    localparam logic [2:0] KIND_FIELD_END  = 3'd1;
    localparam logic [2:0] KIND_ROW_END    = 3'd2;
    localparam logic [2:0] KIND_ERROR      = 3'd3;
    localparam logic [2:0] KIND_TEXT_DONE  = 3'd4;

    localparam logic [1:0] ERR_AFTER_CLOSE    = 2'd0;
    localparam logic [1:0] ERR_QUOTE_UNQUOTED = 2'd1;
    localparam logic [1:0] ERR_END_IN_QUOTES  = 2'd2;

    localparam logic [1:0] MARK_START = 2'd0;
    localparam logic [1:0] MARK_EF    = 2'd1;
    localparam logic [1:0] MARK_EFBB  = 2'd2;
    localparam logic [1:0] MARK_DONE  = 2'd3;

    localparam logic [7:0] CH_BOM0  = 8'hEF;
    localparam logic [7:0] CH_BOM1  = 8'hBB;
    localparam logic [7:0] CH_BOM2  = 8'hBF;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [1:0]
    {
        MODE_OUT    = 2'd0,
        MODE_IN     = 2'd1,
        MODE_PEND   = 2'd2,
        MODE_CLOSED = 2'd3
    } mode_t;

endpackage

`default_nettype wire

/* src/csvt_core.sv */
// Tokenizer state and the single-pass step logic for one input transaction.
// Produces up to four packed results per transaction; depends on csvt_pkg.
`default_nettype none

module csvt_core #(
    parameter int POS_W = csvt_pkg::POSITION_WIDTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic delimiter_is_tab,
    input  wire logic in_cmd,
    input  wire logic [7:0] in_byte,
    input  wire logic advance,
    output logic [3:0][3 + ((10 + 2*POS_W + 7) / 8) * 8 - 1:0] res_list,
    output logic [2:0] res_count
);
    import csvt_pkg::*;

    localparam int DATA_W  = ((10 + 2*POS_W + 7) / 8) * 8;
    localparam int ENTRY_W = 3 + DATA_W;

    typedef struct packed {
        mode_t            mode;
        logic             field_started;
        logic             row_has;
        logic             skip_lf;
        logic             err;
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] col;
    } pst_t;

    typedef struct packed {
        logic             v;
        logic [2:0]       kind;
        logic [7:0]       b;
        logic [1:0]       code;
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] col;
    } res_t;

    typedef struct packed {
        pst_t st;
        res_t r;
    } feed_t;

    localparam pst_t ST_CLEAR = '{mode: MODE_OUT, field_started: 1'b0, row_has: 1'b0,
                                  skip_lf: 1'b0, err: 1'b0, line: POS_W'(1),
                                  col: POS_W'(1)};

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (&v) ? v : v + POS_W'(1);
    endfunction

    function automatic res_t mk_res(input logic [2:0] kind, input logic [7:0] b,
                                    input logic [1:0] code, input pst_t s);
        res_t r;
        r      = '0;
        r.v    = 1'b1;
        r.kind = kind;
        if (kind == KIND_FIELD_BYTE)
        begin
            r.b = b;
        end
        if (kind == KIND_ERROR)
        begin
            r.code = code;
            r.line = s.line;
            r.col  = s.col;
        end
        return r;
    endfunction

    function automatic feed_t feed(input pst_t s_in, input logic [7:0] b,
                                   input logic [7:0] delim);
        feed_t f;
        pst_t  s;
        logic  eol;
        logic  done;
        s    = s_in;
        f    = '0;
        eol  = (b == CH_CR) || (b == CH_LF);
        done = s.err;
        if (!done && s.skip_lf)
        begin
            s.skip_lf = 1'b0;
            if (b == CH_LF)
            begin
                done = 1'b1;
                if (s.mode == MODE_IN)
                begin
                    s.row_has = 1'b1;
                    f.r       = mk_res(KIND_FIELD_BYTE, b, 2'd0, s);
                end
            end
        end
        if (!done && s.mode == MODE_PEND)
        begin
            if (b == CH_QUOTE)
            begin
                s.mode    = MODE_IN;
                s.row_has = 1'b1;
                s.col     = sat_inc(s.col);
                f.r       = mk_res(KIND_FIELD_BYTE, b, 2'd0, s);
                done      = 1'b1;
            end
            else
            begin
                s.mode = MODE_CLOSED;
            end
        end
        if (!done && s.mode == MODE_IN)
        begin
            done = 1'b1;
            if (b == CH_QUOTE)
            begin
                s.mode = MODE_PEND;
                s.col  = sat_inc(s.col);
            end
            else
            begin
                s.row_has = 1'b1;
                f.r       = mk_res(KIND_FIELD_BYTE, b, 2'd0, s);
                if (eol)
                begin
                    s.line    = sat_inc(s.line);
                    s.col     = POS_W'(1);
                    s.skip_lf = (b == CH_CR);
                end
                else
                begin
                    s.col = sat_inc(s.col);
                end
            end
        end
        if (!done && s.mode == MODE_CLOSED && b != delim && !eol)
        begin
            f.r   = mk_res(KIND_ERROR, 8'd0, ERR_AFTER_CLOSE, s);
            s.err = 1'b1;
            done  = 1'b1;
        end
        if (!done)
        begin
            if (b == CH_QUOTE)
            begin
                if (s.field_started)
                begin
                    f.r   = mk_res(KIND_ERROR, 8'd0, ERR_QUOTE_UNQUOTED, s);
                    s.err = 1'b1;
                end
                else
                begin
                    s.mode          = MODE_IN;
                    s.field_started = 1'b1;
                    s.col           = sat_inc(s.col);
                end
            end
            else if (b == delim)
            begin
                f.r             = mk_res(KIND_FIELD_END, 8'd0, 2'd0, s);
                s.row_has       = 1'b1;
                s.field_started = 1'b0;
                s.mode          = MODE_OUT;
                s.col           = sat_inc(s.col);
            end
            else if (eol)
            begin
                if (s.row_has)
                begin
                    f.r = mk_res(KIND_ROW_END, 8'd0, 2'd0, s);
                end
                s.row_has       = 1'b0;
                s.field_started = 1'b0;
                s.mode          = MODE_OUT;
                s.line          = sat_inc(s.line);
                s.col           = POS_W'(1);
                s.skip_lf       = (b == CH_CR);
            end
            else
            begin
                f.r             = mk_res(KIND_FIELD_BYTE, b, 2'd0, s);
                s.field_started = 1'b1;
                s.row_has       = 1'b1;
                s.col           = sat_inc(s.col);
            end
        end
        f.st = s;
        return f;
    endfunction

    function automatic logic [ENTRY_W-1:0] pack(input res_t r);
        return {r.kind, DATA_W'({r.col, r.line, r.code, r.b})};
    endfunction

    pst_t       st_reg;
    pst_t       st_next;
    logic [1:0] mark_reg;
    logic [1:0] mark_next;

    logic [7:0] delim;
    feed_t      f1;
    feed_t      f2;
    feed_t      f3;
    pst_t       st1;
    pst_t       st2;
    pst_t       st_end;
    res_t [3:0] slot;
    logic       replay_ef;
    logic       replay_bb;

    always_comb
    begin
        delim     = delimiter_is_tab ? CH_TAB : CH_COMMA;
        replay_ef = (mark_reg == MARK_EF) || (mark_reg == MARK_EFBB);
        replay_bb = (mark_reg == MARK_EFBB);
        f1        = feed(st_reg, CH_BOM0, delim);
        st1       = replay_ef ? f1.st : st_reg;
        f2        = feed(st1, CH_BOM1, delim);
        st2       = replay_bb ? f2.st : st1;
        f3        = feed(st2, in_byte, delim);
        st_next   = st_reg;
        mark_next = mark_reg;
        slot      = '0;
        st_end    = st2;

        if (in_cmd == CMD_BYTE)
        begin
            if (st_reg.err)
            begin
                st_next = st_reg;
            end
            else if (mark_reg == MARK_START && in_byte == CH_BOM0)
            begin
                mark_next = MARK_EF;
            end
            else if (mark_reg == MARK_EF && in_byte == CH_BOM1)
            begin
                mark_next = MARK_EFBB;
            end
            else if (mark_reg == MARK_EFBB && in_byte == CH_BOM2)
            begin
                mark_next = MARK_DONE;
            end
            else
            begin
                mark_next = MARK_DONE;
                slot[0]   = replay_ef ? f1.r : '0;
                slot[1]   = replay_bb ? f2.r : '0;
                slot[2]   = f3.r;
                st_next   = f3.st;
            end
        end
        else
        begin
            if (!st_reg.err)
            begin
                slot[0] = replay_ef ? f1.r : '0;
                slot[1] = replay_bb ? f2.r : '0;
                if (st_end.mode == MODE_PEND)
                begin
                    st_end.mode = MODE_CLOSED;
                end
                if (!st_end.err)
                begin
                    if (st_end.mode == MODE_IN)
                    begin
                        slot[2] = mk_res(KIND_ERROR, 8'd0, ERR_END_IN_QUOTES, st_end);
                    end
                    else if (st_end.row_has)
                    begin
                        slot[2] = mk_res(KIND_ROW_END, 8'd0, 2'd0, st_end);
                    end
                end
            end
            slot[3]   = mk_res(KIND_TEXT_DONE, 8'd0, 2'd0, st_reg);
            st_next   = ST_CLEAR;
            mark_next = MARK_START;
        end
    end

    always_comb
    begin
        res_list  = '0;
        res_count = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (slot[i].v)
            begin
                res_list[res_count[1:0]] = pack(slot[i]);
                res_count                = res_count + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_CLEAR;
            mark_reg <= MARK_START;
        end
        else if (advance)
        begin
            st_reg   <= st_next;
            mark_reg <= mark_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.err |-> mark_reg == MARK_DONE)
    else $error("error hold set while the byte-order mark check is open");

    assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.mode == MODE_PEND |-> !st_reg.skip_lf)
    else $error("pending quote decision with an LF skip outstanding");

    assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.line != '0 && st_reg.col != '0)
    else $error("line or column counter reached zero");

endmodule

`default_nettype wire

/* src/csvt_outbuf.sv */
// Result buffer holding the up to four results of one transaction.
// Drains them one per cycle onto the master stream while m_tready is high; depends on csvt_pkg.
`default_nettype none

module csvt_outbuf #(
    parameter int POS_W = csvt_pkg::POSITION_WIDTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load,
    input  wire logic [2:0] load_count,
    input  wire logic [3:0][3 + ((10 + 2*POS_W + 7) / 8) * 8 - 1:0] load_data,
    output logic free,
    output logic m_tvalid,
    input  wire logic m_tready,
    output logic [((10 + 2*POS_W + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [2:0] m_tuser,
    output logic m_tlast
);
    import csvt_pkg::*;

    localparam int DATA_W  = ((10 + 2*POS_W + 7) / 8) * 8;
    localparam int ENTRY_W = 3 + DATA_W;

    logic [3:0][ENTRY_W-1:0] ent_reg;
    logic [2:0]              rem_reg;
    logic [1:0]              idx_reg;
    logic [ENTRY_W-1:0]      head;

    assign head     = ent_reg[idx_reg];
    assign m_tvalid = (rem_reg != 3'd0);
    assign m_tlast  = (rem_reg == 3'd1);
    assign m_tdata  = head[DATA_W-1:0];
    assign m_tuser  = head[ENTRY_W-1:DATA_W];
    assign free     = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && m_tready);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ent_reg <= load_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else if (load)
        begin
            rem_reg <= load_count;
            idx_reg <= 2'd0;
        end
        else if (m_tvalid && m_tready)
        begin
            rem_reg <= rem_reg - 3'd1;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= 3'd4)
    else $error("result buffer holds more than four results");

    assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg != 3'd0 |-> {1'b0, idx_reg} + rem_reg <= 3'd4)
    else $error("result buffer read index runs past the loaded results");

    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
    else $error("result buffer reloaded before it drained");

endmodule

`default_nettype wire

/* src/csv_stream_tokenizer_top.sv */
// Top level of the delimited-text tokenizer: input register, delimiter register,
// step logic and result buffer. Depends on csvt_pkg, csvt_core and csvt_outbuf.
//
// Usage:
//   The slave stream takes one transaction per text byte (s_tuser = 0, byte in
//   s_tdata) or an end-of-text transaction (s_tuser = 1), which flushes the
//   open row, reports unclosed quotes and restarts the tokenizer.
//   The master stream delivers results: m_tuser is the kind, m_tdata carries
//   the field byte, error code, error line and error column, and m_tlast marks
//   the final result caused by one input transaction.
//   The delimiter register (cfg_data: 0 comma, 1 tab) is written through the
//   cfg channel, which is always ready; write it only while the block is idle.
//   A transaction is captured in the input register; its results are registered
//   in the result buffer. Throughput is one transaction per cycle while each
//   yields at most one result and the receiver is ready; after one yielding more,
//   the next waits in the input register while the buffer drains one per cycle.
//   When the receiver stalls the buffer holds its results and the input
//   register holds one further transaction before s_tready falls.
//   Reset clears the tokenizer to the start of text and selects comma.
`default_nettype none

module csv_stream_tokenizer_top #(
    parameter int POS_W = csvt_pkg::POSITION_WIDTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic s_tready,
    input  wire logic [7:0] s_tdata,  // text_byte
    input  wire logic s_tuser,        // cmd
    output logic m_tvalid,
    input  wire logic m_tready,
    // field_byte, error_code, error_line, error_column, zero fill
    output logic [((10 + 2*POS_W + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [2:0] m_tuser,       // kind
    output logic m_tlast,
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic cfg_data        // delimiter_is_tab
);
    import csvt_pkg::*;

    localparam int DATA_W  = ((10 + 2*POS_W + 7) / 8) * 8;
    localparam int ENTRY_W = 3 + DATA_W;

    logic                    in_valid_reg;
    logic                    in_cmd_reg;
    logic [7:0]              in_byte_reg;
    logic                    delim_tab_reg;
    logic                    buf_free;
    logic                    advance;
    logic [3:0][ENTRY_W-1:0] res_list;
    logic [2:0]              res_count;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && buf_free;
    assign s_tready  = !in_valid_reg || buf_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            delim_tab_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                delim_tab_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    csvt_core #(
        .POS_W (POS_W)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .delimiter_is_tab (delim_tab_reg),
        .in_cmd           (in_cmd_reg),
        .in_byte          (in_byte_reg),
        .advance          (advance),
        .res_list         (res_list),
        .res_count        (res_count)
    );

    csvt_outbuf #(
        .POS_W (POS_W)
    ) u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .load_count (res_count),
        .load_data  (res_list),
        .free       (buf_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !buf_free |=> in_valid_reg && $stable(in_byte_reg)
            && $stable(in_cmd_reg))
    else $error("held input transaction lost while the result buffer was busy");

endmodule

`default_nettype wire
